@@ hdl/prtf_pkg.sv @@
`timescale 1ns / 1ps
package prtf_pkg;

    localparam int LIST_DEPTH = 5;
    localparam int MAX_QUERY  = 16;
    localparam int INDEX_BITS = 16;

    localparam int CHAR_W    = 8;
    localparam int PREFIX_W  = 5;
    localparam int FREQ_W    = 31;
    localparam int RANK_W    = 3;
    localparam int WIDX_W    = 16;
    localparam int QUERY_W   = 64;
    localparam int QBYTES    = 16;
    localparam int QIDX_W    = 4;
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CASE_GAP  = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        OP_WORD   = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEN  = 2'd2;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [PREFIX_W-1:0]   prefix;
        logic [FREQ_W-1:0]     freq;
    } entry_t;

    // A finished word on its way into the cell row.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } ins_t;

    typedef struct packed {
        logic                valid;
        logic [PREFIX_W-1:0] prefix;
    } word_done_t;

    function automatic logic bytes_match(input logic [CHAR_W-1:0] a,
                                         input logic [CHAR_W-1:0] b);
        logic [CHAR_W:0] ax;
        logic [CHAR_W:0] bx;
        ax = {1'b0, a};
        bx = {1'b0, b};
        return (ax == bx) || (ax + (CHAR_W+1)'(CASE_GAP) == bx)
            || (bx + (CHAR_W+1)'(CASE_GAP) == ax);
    endfunction

endpackage

@@ hdl/prefix_ranked_top_five.sv @@
`timescale 1ns / 1ps
// Word beats and clears are taken every cycle; a word is ranked in the cycle of its last beat.
// A report of n entries yields n result beats (one with found clear for an empty list) on
// consecutive cycles while m_tready is high. A further report waits until the previous report's
// beats have left the snapshot. Word beats keep flowing while a report drains. The cell row
// compares and inserts in the same cycle. aresetn is synchronous and active low: it empties the
// list, zeroes the word counter, restarts prefix tracking and clears the query registers.
module prefix_ranked_top_five (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [prtf_pkg::S_TDATA_W-1:0]   s_tdata,  // char_byte, frequency, zero pad
    input  logic [1:0]                       s_tuser,  // operation
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [prtf_pkg::M_TDATA_W-1:0]   m_tdata,  // rank, word_index, prefix_length,
                                                       // word_frequency, zero pad
    output logic [0:0]                       m_tuser,  // found
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prtf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prtf_pkg::QUERY_W-1:0]     cfg_data
);
    import prtf_pkg::*;

    logic [QUERY_W-1:0]    query_low_reg, query_low_next;
    logic [QUERY_W-1:0]    query_high_reg, query_high_next;
    logic [PREFIX_W-1:0]   query_length_reg, query_length_next;
    logic [INDEX_BITS-1:0] word_number_reg, word_number_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  rep_empty_reg, rep_empty_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                  m_found_reg, m_found_next;
    logic                  m_last_reg, m_last_next;

    op_t        op;
    logic       in_beat;
    logic       word_beat;
    logic       clear;
    logic       snap_load;
    logic       snap_shift;
    logic       out_load;
    word_done_t done;
    ins_t       ins;

    logic   take_chain  [LIST_DEPTH+1];
    entry_t entry_chain [LIST_DEPTH+1];
    entry_t snap_chain  [LIST_DEPTH+1];

    assign op        = op_t'(s_tuser);
    assign s_tready  = !((op == OP_REPORT) && (rem_reg != '0));
    assign in_beat   = s_tvalid && s_tready;
    assign word_beat = in_beat && (op == OP_WORD);
    assign clear     = in_beat && (op == OP_CLEAR);
    assign snap_load = in_beat && (op == OP_REPORT);
    assign out_load  = !m_tvalid_reg || m_tready;
    assign snap_shift = out_load && (rem_reg != '0);
    assign cfg_ready = 1'b1;

    prtf_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .word_beat   (word_beat),
        .clear       (clear),
        .char_byte   (s_tdata[CHAR_W-1:0]),
        .word_end    (s_tlast),
        .query_low   (query_low_reg),
        .query_high  (query_high_reg),
        .query_length(query_length_reg),
        .done        (done)
    );

    always_comb begin
        ins.valid        = done.valid;
        ins.entry.idx    = word_number_reg;
        ins.entry.prefix = done.prefix;
        ins.entry.freq   = s_tdata[CHAR_W +: FREQ_W];
    end

    assign take_chain[0]           = 1'b0;
    assign entry_chain[0]          = ins.entry;
    assign snap_chain[LIST_DEPTH]  = '0;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        prtf_cell u_cell (
            .aclk      (aclk),
            .ins       (ins),
            .occupied  (held_reg > CNT_W'(g)),
            .left_take (take_chain[g]),
            .left_entry(entry_chain[g]),
            .snap_load (snap_load),
            .snap_shift(snap_shift),
            .right_snap(snap_chain[g+1]),
            .take      (take_chain[g+1]),
            .entry     (entry_chain[g+1]),
            .snap      (snap_chain[g])
        );
    end

    always_comb begin
        query_low_next    = query_low_reg;
        query_high_next   = query_high_reg;
        query_length_next = query_length_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_QUERY_LOW:  query_low_next    = cfg_data;
                REG_QUERY_HIGH: query_high_next   = cfg_data;
                REG_QUERY_LEN:  query_length_next = cfg_data[PREFIX_W-1:0];
                default: ;
            endcase
        end

        word_number_next = word_number_reg;
        held_next        = held_reg;
        if (clear) begin
            word_number_next = '0;
            held_next        = '0;
        end else if (done.valid) begin
            word_number_next = word_number_reg + INDEX_BITS'(1);
            if (take_chain[LIST_DEPTH] && (held_reg < CNT_W'(LIST_DEPTH))) begin
                held_next = held_reg + CNT_W'(1);
            end
        end

        rem_next       = rem_reg;
        rep_empty_next = rep_empty_reg;
        rank_next      = rank_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_found_next   = m_found_reg;
        m_last_next    = m_last_reg;

        if (out_load) begin
            m_tvalid_next = 1'b0;
            if (rem_reg != '0) begin
                m_tvalid_next = 1'b1;
                m_found_next  = !rep_empty_reg;
                m_last_next   = (rem_reg == CNT_W'(1));
                if (rep_empty_reg) begin
                    m_tdata_next = '0;
                end else begin
                    m_tdata_next = M_TDATA_W'({snap_chain[0].freq, snap_chain[0].prefix,
                                               WIDX_W'(snap_chain[0].idx), rank_reg});
                end
                rem_next  = rem_reg - CNT_W'(1);
                rank_next = rank_reg + RANK_W'(1);
            end
        end

        // A report is only accepted once the previous report's beats have left the snapshot.
        if (snap_load) begin
            rank_next = '0;
            if (held_reg == '0) begin
                rem_next       = CNT_W'(1);
                rep_empty_next = 1'b1;
            end else begin
                rem_next       = held_reg;
                rep_empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_low_reg    <= '0;
            query_high_reg   <= '0;
            query_length_reg <= '0;
            word_number_reg  <= '0;
            held_reg         <= '0;
            rem_reg          <= '0;
            rep_empty_reg    <= 1'b0;
            rank_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            query_low_reg    <= query_low_next;
            query_high_reg   <= query_high_next;
            query_length_reg <= query_length_next;
            word_number_reg  <= word_number_next;
            held_reg         <= held_next;
            rem_reg          <= rem_next;
            rep_empty_reg    <= rep_empty_next;
            rank_reg         <= rank_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_found_reg <= m_found_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_found_reg;
    assign m_tlast    = m_last_reg;

endmodule

@@ hdl/prtf_match.sv @@
`timescale 1ns / 1ps
module prtf_match (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            word_beat,
    input  logic                            clear,
    input  logic [prtf_pkg::CHAR_W-1:0]     char_byte,
    input  logic                            word_end,
    input  logic [prtf_pkg::QUERY_W-1:0]    query_low,
    input  logic [prtf_pkg::QUERY_W-1:0]    query_high,
    input  logic [prtf_pkg::PREFIX_W-1:0]   query_length,
    output prtf_pkg::word_done_t            done
);
    import prtf_pkg::*;

    logic [PREFIX_W-1:0] char_position_reg, char_position_next;
    logic                still_matching_reg, still_matching_next;
    logic [PREFIX_W-1:0] match_length_reg, match_length_next;

    logic [CHAR_W-1:0]   qbyte [QBYTES];
    logic [PREFIX_W-1:0] qlen;
    logic                hit;
    logic [PREFIX_W-1:0] new_length;

    for (genvar g = 0; g < QBYTES; g++) begin : g_qbyte
        if (g < QUERY_W / CHAR_W) begin : g_low
            assign qbyte[g] = query_low[g*CHAR_W +: CHAR_W];
        end else begin : g_high
            assign qbyte[g] = query_high[(g - QUERY_W/CHAR_W)*CHAR_W +: CHAR_W];
        end
    end

    always_comb begin
        qlen = (query_length > PREFIX_W'(MAX_QUERY)) ? PREFIX_W'(MAX_QUERY) : query_length;
        // Position is below the clamped query length here, so the low bits index safely.
        hit = still_matching_reg && (char_position_reg < qlen)
            && bytes_match(char_byte, qbyte[char_position_reg[QIDX_W-1:0]]);
        new_length = hit ? match_length_reg + PREFIX_W'(1) : match_length_reg;

        char_position_next  = char_position_reg;
        still_matching_next = still_matching_reg;
        match_length_next   = match_length_reg;
        done.valid  = 1'b0;
        done.prefix = new_length;

        if (clear) begin
            char_position_next  = '0;
            still_matching_next = 1'b1;
            match_length_next   = '0;
        end else if (word_beat) begin
            if (word_end) begin
                done.valid          = 1'b1;
                char_position_next  = '0;
                still_matching_next = 1'b1;
                match_length_next   = '0;
            end else begin
                still_matching_next = hit;
                match_length_next   = new_length;
                if (char_position_reg < PREFIX_W'(MAX_QUERY)) begin
                    char_position_next = char_position_reg + PREFIX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_position_reg  <= '0;
            still_matching_reg <= 1'b1;
            match_length_reg   <= '0;
        end else begin
            char_position_reg  <= char_position_next;
            still_matching_reg <= still_matching_next;
            match_length_reg   <= match_length_next;
        end
    end

endmodule

@@ hdl/prtf_cell.sv @@
`timescale 1ns / 1ps
module prtf_cell (
    input  logic             aclk,
    input  prtf_pkg::ins_t   ins,
    input  logic             occupied,
    input  logic             left_take,
    input  prtf_pkg::entry_t left_entry,
    input  logic             snap_load,
    input  logic             snap_shift,
    input  prtf_pkg::entry_t right_snap,
    output logic             take,
    output prtf_pkg::entry_t entry,
    output prtf_pkg::entry_t snap
);
    import prtf_pkg::*;

    entry_t entry_reg, entry_next;
    entry_t snap_reg, snap_next;
    logic   beats;

    always_comb begin
        beats = (ins.entry.prefix != entry_reg.prefix) ? (ins.entry.prefix > entry_reg.prefix)
                                                       : (ins.entry.freq > entry_reg.freq);
        // The list is sorted, so every cell right of the insertion point also takes.
        take = ins.valid && (!occupied || beats);

        entry_next = entry_reg;
        if (left_take) begin
            entry_next = left_entry;
        end else if (take) begin
            entry_next = ins.entry;
        end

        snap_next = snap_reg;
        if (snap_load) begin
            snap_next = entry_reg;
        end else if (snap_shift) begin
            snap_next = right_snap;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        snap_reg  <= snap_next;
    end

    assign entry = entry_reg;
    assign snap  = snap_reg;

endmodule

@@ tb/prefix_ranked_top_five_tb.sv @@
`timescale 1ns / 1ps
module prefix_ranked_top_five_tb;

    import prtf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = 8;
    localparam int TIE_WORDS    = 20;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic                found;
        logic [WIDX_W-1:0]   word_index;
        logic [PREFIX_W-1:0] prefix_length;
        logic [FREQ_W-1:0]   word_frequency;
        logic                last_result;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic              word_last;
        logic [FREQ_W-1:0] freq;
        logic              literal;
        result_t           lit;
    } stim_row_t;

    localparam result_t EMPTY_REPORT = '{3'd0, 1'b0, 16'd0, 5'd0, 31'd0, 1'b1};
    localparam result_t NO_LITERAL   = '0;

    // Query is 'A'..'P' with length 3 while this table runs.
    stim_row_t stim_table [0:20] = '{
        '{OP_REPORT, 8'h00, 1'b0, 31'd0, 1'b1, EMPTY_REPORT},
        '{OP_WORD,   8'h78, 1'b1, 31'h7FFF_FFFF, 1'b0, NO_LITERAL},
        '{OP_REPORT, 8'h00, 1'b0, 31'd0, 1'b1,
          '{3'd0, 1'b1, 16'd0, 5'd0, 31'h7FFF_FFFF, 1'b1}},
        '{OP_NONE,   8'hFF, 1'b1, 31'h7FFF_FFFF, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h61, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h42, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h23, 1'b1, 31'd5, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h00, 1'b1, 31'd0, 1'b0, NO_LITERAL},
        '{OP_REPORT, 8'h00, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h41, 1'b1, 31'd5, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h41, 1'b1, 31'd5, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h62, 1'b1, 31'd9, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'hFF, 1'b1, 31'd0, 1'b0, NO_LITERAL},
        '{OP_REPORT, 8'hFF, 1'b1, 31'h7FFF_FFFF, 1'b0, NO_LITERAL},
        '{OP_CLEAR,  8'h00, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_REPORT, 8'h00, 1'b0, 31'd0, 1'b1, EMPTY_REPORT},
        '{OP_WORD,   8'h61, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h62, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h63, 1'b0, 31'd0, 1'b0, NO_LITERAL},
        '{OP_WORD,   8'h64, 1'b1, 31'd1, 1'b0, NO_LITERAL},
        '{OP_REPORT, 8'h00, 1'b0, 31'd0, 1'b1, '{3'd0, 1'b1, 16'd0, 5'd3, 31'd1, 1'b1}}
    };

    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata    = '0;  // char_byte, frequency, zero pad
    logic [1:0]             s_tuser    = OP_NONE;  // operation
    logic                   s_tlast    = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;  // rank, word_index, prefix_length, word_frequency, pad
    logic [0:0]             m_tuser;  // found
    logic                   m_tlast;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index  = REG_QUERY_LOW;
    logic [QUERY_W-1:0]     cfg_data   = '0;

    // Travels with each input beat: set when the table row carries its own expectation.
    logic                   beat_literal        = 1'b0;
    result_t                beat_literal_result = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // Predicted state of the block.
    logic [QUERY_W-1:0]     q_low        = '0;
    logic [QUERY_W-1:0]     q_high       = '0;
    logic [PREFIX_W-1:0]    q_len        = '0;
    int unsigned            char_pos     = 0;
    bit                     matching     = 1'b1;
    int unsigned            match_len    = 0;
    logic [WIDX_W-1:0]      word_number  = '0;
    logic [WIDX_W-1:0]      rk_index  [LIST_DEPTH];
    int unsigned            rk_prefix [LIST_DEPTH];
    logic [FREQ_W-1:0]      rk_freq   [LIST_DEPTH];
    int unsigned            held         = 0;

    result_t pending_results [$];

    prefix_ranked_top_five dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic int unsigned query_byte(input int unsigned pos);
        if (pos < 8)
            return q_low[8*pos +: 8];
        if (pos < QBYTES)
            return q_high[8*(pos-8) +: 8];
        return 0;
    endfunction

    function automatic int predict_ranking(input op_t op, input logic [CHAR_W-1:0] ch,
                                           input logic word_last, input logic [FREQ_W-1:0] freq,
                                           output result_t res [LIST_DEPTH]);
        int unsigned qlen;
        int unsigned qb;
        int unsigned c;
        int unsigned pos;
        int unsigned i;
        qlen = (q_len > MAX_QUERY) ? MAX_QUERY : q_len;
        c = ch;
        for (i = 0; i < LIST_DEPTH; i++)
            res[i] = '0;
        case (op)
            OP_WORD: begin
                qb = query_byte(char_pos);
                if (matching && char_pos < qlen && (c == qb || c + CASE_GAP == qb
                                                    || qb + CASE_GAP == c))
                    match_len++;
                else
                    matching = 1'b0;
                if (char_pos < MAX_QUERY)
                    char_pos++;
                if (word_last) begin
                    // Ties keep arrival order: the newcomer goes behind equal entries.
                    pos = 0;
                    while (pos < held && !((match_len != rk_prefix[pos])
                                           ? (match_len > rk_prefix[pos])
                                           : (freq > rk_freq[pos])))
                        pos++;
                    if (pos < LIST_DEPTH) begin
                        i = (held < LIST_DEPTH) ? held : LIST_DEPTH - 1;
                        while (i > pos) begin
                            rk_index[i]  = rk_index[i-1];
                            rk_prefix[i] = rk_prefix[i-1];
                            rk_freq[i]   = rk_freq[i-1];
                            i--;
                        end
                        rk_index[pos]  = word_number;
                        rk_prefix[pos] = match_len;
                        rk_freq[pos]   = freq;
                        if (held < LIST_DEPTH)
                            held++;
                    end
                    word_number++;
                    char_pos  = 0;
                    matching  = 1'b1;
                    match_len = 0;
                end
                return 0;
            end
            OP_REPORT: begin
                if (held == 0) begin
                    res[0] = EMPTY_REPORT;
                    return 1;
                end
                for (i = 0; i < held; i++)
                    res[i] = '{RANK_W'(i), 1'b1, rk_index[i], PREFIX_W'(rk_prefix[i]),
                               rk_freq[i], (i + 1 == held)};
                return held;
            end
            OP_CLEAR: begin
                held        = 0;
                word_number = '0;
                char_pos    = 0;
                matching    = 1'b1;
                match_len   = 0;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic check_result_beat(input result_t got);
        result_t want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: rank %0d index %0d",
                   got.rank, got.word_index);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.rank !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, got.rank);
            fail_count++;
        end
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
        end
        if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
            fail_count++;
        end
        if (got.prefix_length !== want.prefix_length) begin
            $error("prefix_length: expected %0d, got %0d",
                   want.prefix_length, got.prefix_length);
            fail_count++;
        end
        if (got.word_frequency !== want.word_frequency) begin
            $error("word_frequency: expected %0d, got %0d",
                   want.word_frequency, got.word_frequency);
            fail_count++;
        end
        if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
            fail_count++;
        end
    endtask

    // Every handshake is observed here, in the order config, input, output.
    always @(posedge aclk) begin : observe
        result_t predicted [LIST_DEPTH];
        int      n;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_QUERY_LOW:  q_low  = cfg_data;
                    REG_QUERY_HIGH: q_high = cfg_data;
                    REG_QUERY_LEN:  q_len  = cfg_data[PREFIX_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                n = predict_ranking(op_t'(s_tuser), s_tdata[CHAR_W-1:0], s_tlast,
                                    s_tdata[CHAR_W +: FREQ_W], predicted);
                if (beat_literal)
                    pending_results = {pending_results, beat_literal_result};
                else
                    for (int k = 0; k < n; k++)
                        pending_results = {pending_results, predicted[k]};
            end
            if (m_tvalid && m_tready)
                check_result_beat('{m_tdata[2:0], m_tuser[0], m_tdata[18:3], m_tdata[23:19],
                                    m_tdata[54:24], m_tlast});
        end
    end

    task automatic send_beat(input op_t op, input logic [CHAR_W-1:0] ch,
                             input logic word_last, input logic [FREQ_W-1:0] freq,
                             input logic literal, input result_t lit);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid            <= 1'b1;
        s_tdata             <= {1'b0, freq, ch};
        s_tuser             <= op;
        s_tlast             <= word_last;
        beat_literal        <= literal;
        beat_literal_result <= lit;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Operations other than word bytes carry random filler in the unused fields.
    task automatic send_command(input op_t op);
        send_beat(op, CHAR_W'($urandom), $urandom_range(0, 1), FREQ_W'($urandom),
                  1'b0, NO_LITERAL);
    endtask

    function automatic logic [FREQ_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return FREQ_W'($urandom_range(1, 3));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    // Usually the query's byte, as it is or shifted by the case gap, otherwise noise.
    function automatic logic [CHAR_W-1:0] pick_word_byte(input int unsigned pos);
        int unsigned qb;
        qb = query_byte(pos);
        if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
                0: return (qb < 256 - CASE_GAP) ? CHAR_W'(qb + CASE_GAP) : CHAR_W'(qb);
                1: return (qb >= CASE_GAP) ? CHAR_W'(qb - CASE_GAP) : CHAR_W'(qb);
                default: return CHAR_W'(qb);
            endcase
        end
        if ($urandom_range(0, 1))
            return $urandom_range(0, 1) ? 8'h20 : 8'h00;
        return CHAR_W'($urandom);
    endfunction

    task automatic send_word(input int unsigned len, input logic finish_word);
        for (int unsigned p = 0; p < len; p++)
            send_beat(OP_WORD, pick_word_byte(p), finish_word && (p == len - 1),
                      (finish_word && p == len - 1) ? pick_count() : FREQ_W'($urandom),
                      1'b0, NO_LITERAL);
    endtask

    task automatic run_random(input int beats_wanted);
        int          sent;
        int unsigned len;
        int unsigned sel;
        sent = 0;
        while (sent < beats_wanted) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                len = $urandom_range(1, ((q_len > MAX_QUERY) ? MAX_QUERY : q_len) + 4);
                send_word(len, 1'b1);
                sent += len;
            end else if (sel < 75) begin
                send_command(OP_REPORT);
                sent++;
            end else if (sel < 80) begin
                send_command(OP_CLEAR);
                sent++;
            end else if (sel < 85) begin
                send_command(OP_NONE);
            end else begin
                // A word cut short, possibly abandoned by a clear.
                len = $urandom_range(1, 4);
                send_word(len, 1'b0);
                sent += len;
                if ($urandom_range(0, 1)) begin
                    send_command(OP_CLEAR);
                    sent++;
                end
            end
        end
    endtask

    task automatic settle_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QUERY_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 80;
        write_reg(REG_QUERY_LOW,  64'h4847_4645_4443_4241);
        write_reg(REG_QUERY_HIGH, 64'h504F_4E4D_4C4B_4A49);
        write_reg(REG_QUERY_LEN,  64'd3);
        foreach (stim_table[r])
            send_beat(stim_table[r].op, stim_table[r].ch, stim_table[r].word_last,
                      stim_table[r].freq, stim_table[r].literal, stim_table[r].lit);
        run_random(30);

        // An oversized length must act as the full sixteen bytes.
        settle_block();
        send_idle_pct = 80;
        recv_idle_pct = 37;
        write_reg(REG_QUERY_LOW,  {$urandom, $urandom});
        write_reg(REG_QUERY_HIGH, {$urandom, $urandom});
        write_reg(REG_QUERY_LEN,  64'd31);
        run_random(30);

        // Empty query: every word ties on prefix, so only counts and arrival decide.
        settle_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_QUERY_LOW,  '1);
        write_reg(REG_QUERY_HIGH, '0);
        write_reg(REG_QUERY_LEN,  64'd0);
        send_command(OP_CLEAR);
        for (int w = 0; w < TIE_WORDS; w++)
            send_beat(OP_WORD, CHAR_W'(w), 1'b1, (w % 3 == 0) ? 31'd4 : 31'd3,
                      1'b0, NO_LITERAL);
        send_command(OP_REPORT);
        run_random(20);

        settle_block();
        write_reg(REG_QUERY_LOW,  '0);
        write_reg(REG_QUERY_HIGH, '1);
        write_reg(REG_QUERY_LEN,  64'd16);
        run_random(30);

        settle_block();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
